/* design/ascii_frame_sum8_checker_unit_defines.svh */
// ----------------------------------------------------------------------------
// ascii_frame_sum8_checker_unit_defines
// assertion macros used by the port-level checker
// ----------------------------------------------------------------------------
`ifndef ASCII_FRAME_SUM8_CHECKER_UNIT_DEFINES_SVH
`define ASCII_FRAME_SUM8_CHECKER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define AFS8_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define AFS8_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/afs8_pkg.sv */
// ----------------------------------------------------------------------------
// afs8_pkg
// shared types and character codes of the ascii frame sum8 checker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package afs8_pkg;

    localparam logic [7:0] CHAR_LT    = 8'h3C;  // '<'
    localparam logic [7:0] CHAR_GT    = 8'h3E;  // '>'
    localparam logic [7:0] CHAR_SEMI  = 8'h3B;  // ';'
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
    localparam logic [7:0] CHAR_MINUS = 8'h2D;  // '-'
    localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CHAR_NINE  = 8'h39;  // '9'

    // largest magnitude still tracked (2^31)
    localparam logic [35:0] VALUE_LIMIT = 36'h0_8000_0000;

    localparam int BYTE_W  = 8;
    localparam int VALUE_W = 32;
    localparam int TDATA_W = 24;

    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_FIELD_COUNT = 2'd1,
        STATUS_NOT_NUMERIC = 2'd2,
        STATUS_MISMATCH    = 2'd3
    } status_t;

    typedef struct packed {
        logic sign;
        logic digit;
        logic bad;
        logic ovf;
        logic neg;
    } field_flags_t;

    typedef struct packed {
        logic [BYTE_W-1:0] received_sum;
        logic [BYTE_W-1:0] computed_sum;
        logic              accepted;
        status_t           status;
    } result_t;

endpackage

/* design/ascii_frame_sum8_checker_unit.sv */
// ----------------------------------------------------------------------------
// ascii_frame_sum8_checker_unit
// checks '<' ... '>' text frames: separator count, decimal checksum field
// and the 8-bit byte sum of everything before the last separator
// ----------------------------------------------------------------------------
//
//  channel   dir   tdata bits (low to high)                      item
//  s_axis    in    rx_byte[7:0]                                   one character
//  m_axis    out   status[1:0] accepted[2] computed_sum[10:3]     one frame report
//                  received_sum[18:11], zero pad [23:19]
//  cfg       in    cfg_wdata = accept_mismatch                    register write
//
//  one item per cycle in while the result register can take a report; each
//  byte is held in the input register and folded into the frame state when
//  the core moves it; a closing '>' loads the result register on that edge,
//  where its report waits as valid until the sink takes it
//  rst_n clears frame state, valid flags and accept_mismatch
//  a full result register that is not drained stalls the input side
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ascii_frame_sum8_checker_unit
    import afs8_pkg::*;
#(
    parameter int FIELD_COUNT = 24
)
(
    input  logic               clk,
    input  logic               rst_n,
    // input stream: rx_byte[7:0]
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [BYTE_W-1:0]  s_tdata,
    // output stream: status[1:0], accepted[2], computed_sum[10:3],
    // received_sum[18:11], zeros above
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,
    // configuration: accept_mismatch
    input  logic               cfg_we,
    input  logic               cfg_wdata
);

    logic              accept_mismatch_reg;
    logic              accept_mismatch_next;
    logic              byte_vld;
    logic [BYTE_W-1:0] byte_q;
    logic              advance;
    logic              res_vld;
    result_t           result;

    // debug mode register: accept frames whose checksum disagrees
    always_comb
    begin
        accept_mismatch_next = accept_mismatch_reg;
        if (cfg_we)
        begin
            accept_mismatch_next = cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accept_mismatch_reg <= 1'b0;
        end
        else
        begin
            accept_mismatch_reg <= accept_mismatch_next;
        end
    end

    // the core moves one byte whenever the result register can take a report
    assign advance = byte_vld && (!m_tvalid || m_tready);

    afs8_input_stage u_input_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_byte   (s_tdata),
        .advance  (advance),
        .byte_vld (byte_vld),
        .byte_out (byte_q)
    );

    afs8_frame_core #(
        .FIELD_COUNT (FIELD_COUNT)
    ) u_frame_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .advance         (advance),
        .rx_byte         (byte_q),
        .accept_mismatch (accept_mismatch_reg),
        .res_vld         (res_vld),
        .result          (result)
    );

    afs8_output_stage u_output_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (res_vld),
        .result   (result),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

/* design/afs8_input_stage.sv */
// ----------------------------------------------------------------------------
// afs8_input_stage
// input register for received bytes, freed when the core takes the item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module afs8_input_stage
    import afs8_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_byte,
    input  logic              advance,
    output logic              byte_vld,
    output logic [BYTE_W-1:0] byte_out
);

    logic              vld_reg;
    logic              vld_next;
    logic [BYTE_W-1:0] byte_reg;

    assign s_tready = !vld_reg || advance;

    always_comb
    begin
        vld_next = vld_reg;
        if (s_tready)
        begin
            vld_next = s_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            byte_reg <= s_byte;
        end
    end

    assign byte_vld = vld_reg;
    assign byte_out = byte_reg;

endmodule

/* design/afs8_frame_core.sv */
// ----------------------------------------------------------------------------
// afs8_frame_core
// frame state, running sum, separator count and checksum field parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module afs8_frame_core
    import afs8_pkg::*;
#(
    parameter int FIELD_COUNT = 24
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic              accept_mismatch,
    output logic              res_vld,
    output result_t           result
);

    localparam int CNT_W = $clog2(FIELD_COUNT + 1);
    localparam logic [CNT_W-1:0] CNT_SAT  = CNT_W'(FIELD_COUNT);
    localparam logic [CNT_W-1:0] CNT_NEED = CNT_W'(FIELD_COUNT - 1);

    logic               in_frame_reg,  in_frame_next;
    logic [BYTE_W-1:0]  run_sum_reg,   run_sum_next;
    logic [BYTE_W-1:0]  sep_sum_reg,   sep_sum_next;
    logic [CNT_W-1:0]   sep_cnt_reg,   sep_cnt_next;
    logic [VALUE_W-1:0] value_reg,     value_next;
    field_flags_t       flags_reg,     flags_next;

    logic               is_digit;
    logic [3:0]         digit;
    logic [35:0]        value_x10;
    logic               num_ok;
    logic [BYTE_W-1:0]  recv;

    assign is_digit  = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
    assign digit     = 4'(rx_byte - CHAR_ZERO);
    // value * 10 + digit as two shifted copies
    assign value_x10 = {1'b0, value_reg, 3'b000} + {3'b000, value_reg, 1'b0}
                     + {32'd0, digit};

    always_comb
    begin
        in_frame_next = in_frame_reg;
        run_sum_next  = run_sum_reg;
        sep_sum_next  = sep_sum_reg;
        sep_cnt_next  = sep_cnt_reg;
        value_next    = value_reg;
        flags_next    = flags_reg;
        res_vld       = 1'b0;
        if (advance)
        begin
            if (!in_frame_reg)
            begin
                if (rx_byte == CHAR_LT)
                begin
                    in_frame_next = 1'b1;
                    run_sum_next  = '0;
                    sep_sum_next  = '0;
                    sep_cnt_next  = '0;
                    value_next    = '0;
                    flags_next    = '0;
                end
            end
            else if (rx_byte != CHAR_GT)
            begin
                if (rx_byte == CHAR_SEMI)
                begin
                    sep_sum_next = run_sum_reg;
                    if (sep_cnt_reg < CNT_SAT)
                    begin
                        sep_cnt_next = sep_cnt_reg + 1'b1;
                    end
                    value_next = '0;
                    flags_next = '0;
                end
                else if (is_digit)
                begin
                    flags_next.digit = 1'b1;
                    if (!flags_reg.ovf)
                    begin
                        if (value_x10 > VALUE_LIMIT)
                        begin
                            flags_next.ovf = 1'b1;
                        end
                        else
                        begin
                            value_next = value_x10[VALUE_W-1:0];
                        end
                    end
                end
                else if ((rx_byte == CHAR_PLUS || rx_byte == CHAR_MINUS)
                         && !flags_reg.sign && !flags_reg.digit)
                begin
                    flags_next.sign = 1'b1;
                    flags_next.neg  = (rx_byte == CHAR_MINUS);
                end
                else
                begin
                    flags_next.bad = 1'b1;
                end
                run_sum_next = run_sum_reg + rx_byte;
            end
            else
            begin
                // closing byte: report and leave the frame
                res_vld       = 1'b1;
                in_frame_next = 1'b0;
                run_sum_next  = '0;
                sep_sum_next  = '0;
                sep_cnt_next  = '0;
                value_next    = '0;
                flags_next    = '0;
            end
        end
    end

    // positive values stop at 2^31 - 1, negative ones reach -2^31
    assign num_ok = flags_reg.digit && !flags_reg.bad && !flags_reg.ovf
                  && !(!flags_reg.neg && value_reg[VALUE_W-1]);
    assign recv   = flags_reg.neg ? (8'h00 - value_reg[BYTE_W-1:0])
                                  : value_reg[BYTE_W-1:0];

    always_comb
    begin
        result.status       = STATUS_OK;
        result.accepted     = 1'b0;
        result.computed_sum = '0;
        result.received_sum = '0;
        if (sep_cnt_reg != CNT_NEED)
        begin
            result.status = STATUS_FIELD_COUNT;
        end
        else
        begin
            result.computed_sum = sep_sum_reg;
            if (!num_ok)
            begin
                result.status = STATUS_NOT_NUMERIC;
            end
            else
            begin
                result.received_sum = recv;
                if (recv == sep_sum_reg)
                begin
                    result.status   = STATUS_OK;
                    result.accepted = 1'b1;
                end
                else
                begin
                    result.status   = STATUS_MISMATCH;
                    result.accepted = accept_mismatch;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            run_sum_reg  <= '0;
            sep_sum_reg  <= '0;
            sep_cnt_reg  <= '0;
            value_reg    <= '0;
            flags_reg    <= '0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            run_sum_reg  <= run_sum_next;
            sep_sum_reg  <= sep_sum_next;
            sep_cnt_reg  <= sep_cnt_next;
            value_reg    <= value_next;
            flags_reg    <= flags_next;
        end
    end

endmodule

/* design/afs8_output_stage.sv */
// ----------------------------------------------------------------------------
// afs8_output_stage
// result register holding one frame report until the sink takes it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module afs8_output_stage
    import afs8_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  result_t            result,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata
);

    logic    vld_reg;
    logic    vld_next;
    result_t res_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (load)
        begin
            vld_next = 1'b1;
        end
        else if (m_tready)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= result;
        end
    end

    assign m_tvalid = vld_reg;
    assign m_tdata  = {{(TDATA_W - $bits(result_t)){1'b0}}, res_reg};

endmodule

/* design/afs8_checker.sv */
// ----------------------------------------------------------------------------
// afs8_checker
// port-level checks on the frame report stream
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ascii_frame_sum8_checker_unit_defines.svh"

module afs8_checker
    import afs8_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata
);

    status_t           st;
    logic              acc;
    logic [BYTE_W-1:0] comp_sum;
    logic [BYTE_W-1:0] recv_sum;
    logic [15:0]       sums;
    logic              stalled;
    logic              is_ok;
    logic              is_count;
    logic              is_nonnum;

    assign st        = status_t'(m_tdata[1:0]);
    assign acc       = m_tdata[2];
    assign comp_sum  = m_tdata[10:3];
    assign recv_sum  = m_tdata[18:11];
    assign sums      = m_tdata[18:3];
    assign stalled   = m_tvalid && !m_tready;
    assign is_ok     = m_tvalid && (st == STATUS_OK);
    assign is_count  = m_tvalid && (st == STATUS_FIELD_COUNT);
    assign is_nonnum = m_tvalid && (st == STATUS_NOT_NUMERIC);

    `AFS8_ASSERT_NEXT(a_out_hold, stalled, m_tvalid && $stable(m_tdata), "stalled report changed")
    `AFS8_ASSERT_NOW(a_ok_accepted, is_ok, acc && comp_sum == recv_sum, "ok report not accepted")
    `AFS8_ASSERT_NOW(a_count_zero, is_count, !acc && sums == '0, "count report has data")
    `AFS8_ASSERT_NOW(a_numeric_zero, is_nonnum, !acc && recv_sum == '0, "received sum on bad field")
    `AFS8_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[TDATA_W-1:19] == '0, "pad bits set")

endmodule

bind ascii_frame_sum8_checker_unit afs8_checker u_afs8_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* bench/afs8_report_checker.sv */
// ----------------------------------------------------------------------------
// afs8_report_checker
// watches the character and report streams of the ascii frame sum8 checker,
// predicts one report per closing '>' and compares each report field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module afs8_report_checker
    import afs8_pkg::*;
#(
    parameter int FIELD_COUNT = 24
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [BYTE_W-1:0]  s_tdata,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [TDATA_W-1:0] m_tdata,
    input  logic               cfg_we,
    input  logic               cfg_wdata,
    output int                 error_count,
    output int                 reports_due
);

    localparam int REPORT_W = $bits(result_t);

    // predicted frame state
    logic               in_frame;
    logic [BYTE_W-1:0]  running_sum;
    logic [BYTE_W-1:0]  sum_at_semi;
    logic [4:0]         semi_count;
    logic [VALUE_W-1:0] magnitude;
    field_flags_t       flags;
    logic               accept_mismatch;
    result_t            report_queue[$];

    task automatic clear_frame_state();
        running_sum = '0;
        sum_at_semi = '0;
        semi_count  = '0;
        magnitude   = '0;
        flags       = '0;
    endtask

    // folds one accepted character into the frame state, queues a report on '>'
    task automatic fold_char(input logic [BYTE_W-1:0] c);
        logic [VALUE_W+3:0] scaled;
        logic               ok;
        result_t            rep;
        if (!in_frame)
        begin
            if (c == CHAR_LT)
            begin
                in_frame = 1'b1;
                clear_frame_state();
            end
        end
        else if (c != CHAR_GT)
        begin
            if (c == CHAR_SEMI)
            begin
                sum_at_semi = running_sum;
                if (semi_count < FIELD_COUNT)
                    semi_count = semi_count + 5'd1;
                magnitude = '0;
                flags     = '0;
            end
            else if (c >= CHAR_ZERO && c <= CHAR_NINE)
            begin
                flags.digit = 1'b1;
                // accumulation freezes once past 2^31
                if (!flags.ovf)
                begin
                    scaled = magnitude * 36'd10 + (c - CHAR_ZERO);
                    if (scaled > VALUE_LIMIT)
                        flags.ovf = 1'b1;
                    else
                        magnitude = scaled[VALUE_W-1:0];
                end
            end
            else if ((c == CHAR_PLUS || c == CHAR_MINUS) && !flags.sign && !flags.digit)
            begin
                flags.sign = 1'b1;
                if (c == CHAR_MINUS)
                    flags.neg = 1'b1;
            end
            else
                flags.bad = 1'b1;
            running_sum = running_sum + c;
        end
        else
        begin
            rep = '0;
            if (semi_count != 5'(FIELD_COUNT - 1))
                rep.status = STATUS_FIELD_COUNT;
            else
            begin
                // positive values stop at 2^31 - 1, negative ones at -2^31
                ok = flags.digit && !flags.bad && !flags.ovf
                     && (flags.neg || !magnitude[VALUE_W-1]);
                rep.computed_sum = sum_at_semi;
                if (!ok)
                    rep.status = STATUS_NOT_NUMERIC;
                else
                begin
                    rep.received_sum = flags.neg ? (8'd0 - magnitude[7:0]) : magnitude[7:0];
                    if (rep.received_sum == sum_at_semi)
                    begin
                        rep.status   = STATUS_OK;
                        rep.accepted = 1'b1;
                    end
                    else
                    begin
                        rep.status   = STATUS_MISMATCH;
                        rep.accepted = accept_mismatch;
                    end
                end
            end
            report_queue.push_back(rep);
            in_frame = 1'b0;
            clear_frame_state();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            in_frame        = 1'b0;
            accept_mismatch = 1'b0;
            clear_frame_state();
            report_queue.delete();
            error_count     = 0;
            reports_due     = 0;
        end
        else
        begin
            // reports first: a report never belongs to a '>' taken on the same edge
            if (m_tvalid && m_tready)
            begin
                got = result_t'(m_tdata[REPORT_W-1:0]);
                if (report_queue.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("%0t: report %h arrived with none pending", $realtime, m_tdata);
                end
                else
                begin
                    want = report_queue.pop_front();
                    if (got.status !== want.status || got.accepted !== want.accepted
                        || got.computed_sum !== want.computed_sum
                        || got.received_sum !== want.received_sum
                        || m_tdata[TDATA_W-1:REPORT_W] !== '0)
                    begin
                        error_count++;
                        if (error_count <= 10)
                            $display({"%0t: report mismatch: status %0d/%0d accepted %0b/%0b",
                                      " computed_sum %h/%h received_sum %h/%h pad 0/%h",
                                      " (expected/actual)"},
                                     $realtime, want.status, got.status,
                                     want.accepted, got.accepted,
                                     want.computed_sum, got.computed_sum,
                                     want.received_sum, got.received_sum,
                                     m_tdata[TDATA_W-1:REPORT_W]);
                    end
                end
            end
            if (cfg_we)
                accept_mismatch = cfg_wdata;
            if (s_tvalid && s_tready)
                fold_char(s_tdata);
            reports_due = report_queue.size();
        end
    end

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// streams text frames into the ascii frame sum8 checker: stray bytes, frames
// with right and wrong separator counts, good, wrong and malformed checksum
// fields, under both accept_mismatch settings and several idle/stall mixes;
// the report checker beside the block predicts and compares every report
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import afs8_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int FIELD_COUNT   = 24;
    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 4;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [BYTE_W-1:0]  s_tdata;     // rx_byte[7:0]
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;     // status, accepted, computed_sum, received_sum
    logic               cfg_we;
    logic               cfg_wdata;

    int error_count;
    int reports_due;
    int idle_pct     = 0;
    int stall_pct    = 0;
    int quiet_cycles = 0;
    int chars_sent   = 0;
    int frames_sent  = 0;

    // text of the frame under construction and its byte sums
    logic [BYTE_W-1:0] line_text[$];
    logic [BYTE_W-1:0] body_sum;
    logic [BYTE_W-1:0] frame_sum;

    int    odd_seps[8]  = '{0, 1, 2, 22, 24, 25, 31, 40};
    string junk_text[7] = '{"", "-", "+", " 12", "+2147483648", "-2147483649",
                            "99999999999999"};

    always #(HALF_PERIOD) clk = ~clk;

    ascii_frame_sum8_checker_unit #(
        .FIELD_COUNT(FIELD_COUNT)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    afs8_report_checker #(
        .FIELD_COUNT(FIELD_COUNT)
    ) u_report_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .error_count(error_count),
        .reports_due(reports_due)
    );

    // receiver back-pressure
    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= stall_pct);

    // ends the run when no item, report or register write moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // one item; tready is sampled mid-cycle, where nothing is changing
    task automatic send_char(input logic [BYTE_W-1:0] c);
        logic taken;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = s_tready;
            @(posedge clk);
        end
        chars_sent++;
    endtask

    task automatic put(input logic [BYTE_W-1:0] c);
        line_text.push_back(c);
        body_sum = body_sum + c;
    endtask

    task automatic flush_text();
        foreach (line_text[i])
            send_char(line_text[i]);
        line_text.delete();
    endtask

    task automatic add_str(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            put(s[i]);
    endtask

    // any byte that neither splits nor closes a field
    function automatic logic [BYTE_W-1:0] free_byte(input int style);
        logic [BYTE_W-1:0] c;
        do
        begin
            case (style)
                0:       c = CHAR_ZERO + 8'($urandom_range(0, 9));
                1:       c = 8'($urandom_range(32, 126));
                default: c = 8'($urandom_range(0, 255));
            endcase
        end
        while (c == CHAR_SEMI || c == CHAR_GT);
        return c;
    endfunction

    task automatic begin_frame();
        line_text.push_back(CHAR_LT);
        body_sum  = '0;
        frame_sum = '0;
    endtask

    // seps separators, fields empty or short random text; frame_sum is the
    // sum of everything before the last separator
    task automatic add_fields(input int seps, input bit rich);
        int i;
        for (i = 0; i < seps; i++)
        begin
            if (rich)
                repeat ($urandom_range(0, 2))
                begin
                    if ($urandom_range(0, 15) == 0)
                        put(CHAR_LT);
                    else
                        put(free_byte($urandom_range(0, 2)));
                end
            if (i == seps - 1)
                frame_sum = body_sum;
            put(CHAR_SEMI);
        end
    endtask

    task automatic close_frame();
        put(CHAR_GT);
        flush_text();
        frames_sent++;
    endtask

    task automatic add_number(input longint v, input bit plus, input int zeros);
        longint mag;
        if (v < 0)
        begin
            put(CHAR_MINUS);
            mag = -v;
        end
        else
        begin
            mag = v;
            if (plus)
                put(CHAR_PLUS);
        end
        repeat (zeros)
            put(CHAR_ZERO);
        add_str($sformatf("%0d", mag));
    endtask

    // value whose low byte matches the frame sum, in various spellings
    task automatic add_good_tail();
        longint v;
        case ($urandom_range(0, 3))
            0:       v = longint'(frame_sum);
            1:       v = longint'(frame_sum) + 256 * longint'($urandom_range(0, 8388607));
            2:       v = longint'(frame_sum) - 256 * longint'($urandom_range(1, 8388608));
            default: v = longint'(frame_sum) - 256 * longint'($urandom_range(1, 3));
        endcase
        add_number(v, $urandom_range(0, 3) == 0,
                   ($urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : 0);
    endtask

    task automatic add_wrong_tail();
        longint v;
        if ($urandom_range(0, 1) == 1)
            v = longint'(int'($urandom));
        else
            v = longint'($urandom_range(0, 600)) - 300;
        if ((v & 255) == longint'(frame_sum))
            v = v ^ 1;
        add_number(v, $urandom_range(0, 3) == 0, $urandom_range(0, 1));
    endtask

    // checksum fields that do not parse
    task automatic add_junk_tail();
        case ($urandom_range(0, 9))
            0: ;
            1: put($urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
            2:
            begin
                put($urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
                put($urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
                add_number($urandom_range(0, 999), 1'b0, 0);
            end
            3:
            begin
                add_number($urandom_range(0, 999), 1'b0, 0);
                put(free_byte(1) | 8'h40);
                if ($urandom_range(0, 1) == 1)
                    put(free_byte(0));
            end
            4:
            begin
                put(8'h20);
                add_number($urandom_range(0, 999), 1'b0, 0);
            end
            5: add_number(64'sd2147483648 + longint'($urandom_range(0, 1000)),
                          $urandom_range(0, 1), 0);
            6: add_number(-64'sd2147483649 - longint'($urandom_range(0, 1000)), 1'b0, 0);
            7:
            begin
                put(CHAR_ZERO + 8'($urandom_range(1, 9)));
                repeat ($urandom_range(10, 19))
                    put(free_byte(0));
            end
            8:
            begin
                add_number($urandom_range(0, 999), 1'b0, 0);
                put(CHAR_MINUS);
            end
            default:
                repeat ($urandom_range(1, 4))
                    put(free_byte(2));
        endcase
    endtask

    // block goes quiet: no reports pending and the input pipe empty
    task automatic settle();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (reports_due != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic set_accept_mismatch(input bit v);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // mostly well-formed frames with random content, some stray bytes,
    // wrong separator counts and malformed checksum fields
    task automatic run_random(input int idle, input int stall, input int min_chars,
                              input int min_frames);
        int                c0;
        int                f0;
        int                seps;
        int                pick;
        logic [BYTE_W-1:0] c;
        idle_pct  = idle;
        stall_pct = stall;
        c0 = chars_sent;
        f0 = frames_sent;
        while (chars_sent - c0 < min_chars || frames_sent - f0 < min_frames)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 6))
                begin
                    c = 8'($urandom_range(0, 255));
                    if (c == CHAR_LT)
                        c = CHAR_GT;
                    line_text.push_back(c);
                end
                flush_text();
            end
            if ($urandom_range(0, 99) < 85)
                seps = FIELD_COUNT - 1;
            else
                seps = odd_seps[$urandom_range(0, 7)];
            begin_frame();
            add_fields(seps, 1'b1);
            pick = $urandom_range(0, 99);
            if (pick < 65)
                add_good_tail();
            else if (pick < 82)
                add_wrong_tail();
            else
                add_junk_tail();
            close_frame();
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = 1'b0;
        body_sum  = '0;
        frame_sum = '0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;

        // bytes outside a frame, a stray '>' among them, are dropped
        line_text = '{8'h00, 8'hFF, CHAR_GT, CHAR_SEMI, 8'h41};
        flush_text();

        // empty frame: wrong field count
        begin_frame();
        close_frame();

        // minimal well-formed frame
        begin_frame();
        add_fields(FIELD_COUNT - 1, 1'b0);
        add_number(longint'(frame_sum), 1'b0, 0);
        close_frame();

        // extreme bytes and a '<' as data, signed checksum with leading zeros
        begin_frame();
        put(8'h00);
        put(8'hFF);
        put(CHAR_LT);
        add_fields(FIELD_COUNT - 1, 1'b1);
        add_number(longint'(frame_sum), 1'b1, 3);
        close_frame();

        // separator count saturates, one short, one over
        foreach (odd_seps[k])
            if (odd_seps[k] >= 22 && odd_seps[k] != 25)
            begin
                begin_frame();
                add_fields(odd_seps[k], 1'b0);
                add_number(longint'(frame_sum), 1'b0, 0);
                close_frame();
            end

        // checksum field not numeric: empty, sign only, whitespace, out of range
        foreach (junk_text[k])
        begin
            begin_frame();
            add_fields(FIELD_COUNT - 1, 1'b0);
            add_str(junk_text[k]);
            close_frame();
        end

        // range limits of the checksum field
        begin_frame();
        add_fields(FIELD_COUNT - 1, 1'b1);
        add_str("-2147483648");
        close_frame();
        begin_frame();
        add_fields(FIELD_COUNT - 1, 1'b1);
        add_str("2147483647");
        close_frame();

        // negative checksum with matching low byte
        begin_frame();
        add_fields(FIELD_COUNT - 1, 1'b1);
        add_number(longint'(frame_sum) - 256, 1'b0, 0);
        close_frame();

        // mismatch rejected, then accepted in debug mode
        begin_frame();
        add_fields(FIELD_COUNT - 1, 1'b0);
        add_number(longint'(frame_sum ^ 8'h80), 1'b0, 0);
        close_frame();
        set_accept_mismatch(1'b1);
        begin_frame();
        add_fields(FIELD_COUNT - 1, 1'b0);
        add_number(longint'(frame_sum ^ 8'h01), 1'b0, 0);
        close_frame();
        begin_frame();
        add_fields(FIELD_COUNT - 1, 1'b1);
        add_good_tail();
        close_frame();

        // random phases, the register toggling between them
        run_random(0, 0, 180, 3);
        set_accept_mismatch(1'b0);
        run_random(70, 0, 180, 3);
        set_accept_mismatch(1'b1);
        run_random(0, 70, 180, 3);
        set_accept_mismatch(1'b0);
        run_random(21, 21, 180, 3);

        settle();
        if (error_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

/* sim.f */
+incdir+design
design/afs8_pkg.sv
design/afs8_input_stage.sv
design/afs8_frame_core.sv
design/afs8_output_stage.sv
design/ascii_frame_sum8_checker_unit.sv
design/afs8_checker.sv
bench/afs8_report_checker.sv
bench/tb_top.sv
